@@ rtl/sfr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the SBUS frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int TICK_W        = 16;
    localparam int TIMEOUT_W     = 16;
    localparam int CMP_W         = (TICK_W > TIMEOUT_W) ? TICK_W : TIMEOUT_W;
    localparam int TIMEOUT_RESET = 10;

    localparam int DATA_BYTES    = 23;
    localparam int FRAME_W       = DATA_BYTES * 8;
    localparam int BYTE_CNT_W    = 5;
    localparam int CHAN_W        = 11;
    localparam int CHAN_IDX_W    = 5;
    localparam int NUM_PROP      = 16;

    localparam logic [7:0] SYNC_BYTE = 8'h0F;

    localparam logic [CHAN_IDX_W-1:0] CH_DIG0 = CHAN_IDX_W'(NUM_PROP);
    localparam logic [CHAN_IDX_W-1:0] CH_DIG1 = CHAN_IDX_W'(NUM_PROP + 1);

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_UART_ERR = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    typedef enum logic [1:0] {
        STS_DATA       = 2'd0,
        STS_BAD_HEADER = 2'd1,
        STS_UART_ERR   = 2'd2,
        STS_TIMEOUT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_HEAD = 2'd0,
        ST_DATA = 2'd1,
        ST_FOOT = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic    load_chan;
        logic    load_status;
        status_t status;
        logic    tick_inc;
        logic    tick_clr;
        logic    cnt_clr;
        logic    shift_in;
        logic    cap_flags;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic data_done;
        logic tick_expire;
        logic sync_hit;
        logic chan_last;
    } stat_t;

endpackage

@@ rtl/sfr_ctrl.sv @@
// Controller state machine: frame phase tracking and command generation.
`timescale 1ns / 1ps

module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STS_DATA;
        in_stall   = (state_reg == ST_EMIT) || !stat.out_free;
        accept     = in_valid && !in_stall;

        priority if (state_reg == ST_EMIT)
        begin
            // One channel word per free output slot until the last one is sent.
            if (stat.out_free)
            begin
                cmd.load_chan = 1'b1;
                if (stat.chan_last)
                begin
                    state_next = ST_HEAD;
                end
            end
        end
        else if (accept)
        begin
            unique case (kind)
                KIND_UART_ERR:
                begin
                    cmd.load_status = 1'b1;
                    cmd.status      = STS_UART_ERR;
                    cmd.tick_clr    = 1'b1;
                    cmd.cnt_clr     = 1'b1;
                    state_next      = ST_HEAD;
                end
                KIND_TICK:
                begin
                    if (stat.tick_expire)
                    begin
                        cmd.load_status = 1'b1;
                        cmd.status      = STS_TIMEOUT;
                        cmd.tick_clr    = 1'b1;
                        cmd.cnt_clr     = 1'b1;
                        state_next      = ST_HEAD;
                    end
                    else
                    begin
                        cmd.tick_inc = 1'b1;
                    end
                end
                KIND_BYTE:
                begin
                    unique case (state_reg)
                        ST_DATA:
                        begin
                            cmd.shift_in = 1'b1;
                            if (stat.data_done)
                            begin
                                cmd.tick_clr = 1'b1;
                                state_next   = ST_FOOT;
                            end
                        end
                        ST_FOOT:
                        begin
                            cmd.cap_flags = 1'b1;
                            cmd.tick_clr  = 1'b1;
                            cmd.cnt_clr   = 1'b1;
                            state_next    = ST_EMIT;
                        end
                        default:
                        begin
                            cmd.tick_clr = 1'b1;
                            cmd.cnt_clr  = 1'b1;
                            if (stat.sync_hit)
                            begin
                                state_next = ST_DATA;
                            end
                            else
                            begin
                                cmd.load_status = 1'b1;
                                cmd.status      = STS_BAD_HEADER;
                                state_next      = ST_HEAD;
                            end
                        end
                    endcase
                end
                default:
                begin
                    // Unknown kind: no effect.
                end
            endcase
        end
        else
        begin
            // Nothing taken this cycle.
        end
    end

endmodule

@@ rtl/sfr_datapath.sv @@
// Datapath: timeout register, tick and byte counters, frame shift line and result register.
`timescale 1ns / 1ps

module sfr_datapath
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [TIMEOUT_W-1:0]  timeout_ticks,
    input  logic [7:0]            rx_byte,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [CHAN_IDX_W-1:0] channel_index,
    output logic [CHAN_W-1:0]     channel_value,
    output logic                  frame_drop,
    output logic                  failsafe,
    output logic                  last
);

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [TICK_W-1:0]     tick_reg;
    logic [TICK_W-1:0]     tick_sat;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg;
    logic [CHAN_IDX_W-1:0] chan_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic [7:0]            flags_reg;

    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [CHAN_IDX_W-1:0] index_reg;
    logic [CHAN_W-1:0]     value_reg;
    logic                  lost_reg;
    logic                  fs_reg;
    logic                  last_reg;
    logic [CHAN_W-1:0]     chan_value;

    assign tick_sat = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;

    assign stat.out_free    = !out_valid_reg || !out_stall;
    assign stat.data_done   = (byte_cnt_reg == BYTE_CNT_W'(DATA_BYTES - 1));
    assign stat.tick_expire = (CMP_W'(tick_sat) >= CMP_W'(timeout_reg));
    assign stat.sync_hit    = (rx_byte == SYNC_BYTE);
    assign stat.chan_last   = (chan_reg == CH_DIG1);

    always_comb
    begin
        priority if (chan_reg < CH_DIG0)
        begin
            chan_value = frame_reg[CHAN_W-1:0];
        end
        else if (chan_reg == CH_DIG0)
        begin
            chan_value = CHAN_W'(flags_reg[0]);
        end
        else
        begin
            chan_value = CHAN_W'(flags_reg[1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_W'(TIMEOUT_RESET);
            tick_reg      <= '0;
            byte_cnt_reg  <= '0;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                timeout_reg <= timeout_ticks;
            end

            if (cmd.tick_clr)
            begin
                tick_reg <= '0;
            end
            else if (cmd.tick_inc)
            begin
                tick_reg <= tick_sat;
            end

            if (cmd.cnt_clr)
            begin
                byte_cnt_reg <= '0;
            end
            else if (cmd.shift_in)
            begin
                byte_cnt_reg <= byte_cnt_reg + 1'b1;
            end

            if (cmd.cap_flags)
            begin
                chan_reg <= '0;
            end
            else if (cmd.load_chan)
            begin
                chan_reg <= chan_reg + 1'b1;
            end

            if (cmd.load_chan || cmd.load_status)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.shift_in)
        begin
            frame_reg <= {rx_byte, frame_reg[FRAME_W-1:8]};
        end
        else if (cmd.load_chan && (chan_reg < CH_DIG0))
        begin
            frame_reg <= frame_reg >> CHAN_W;
        end

        if (cmd.cap_flags)
        begin
            flags_reg <= frame_reg[FRAME_W-1 -: 8];
        end

        if (cmd.load_chan)
        begin
            status_reg <= STS_DATA;
            index_reg  <= chan_reg;
            value_reg  <= chan_value;
            lost_reg   <= flags_reg[2];
            fs_reg     <= flags_reg[3];
            last_reg   <= (chan_reg == CH_DIG1);
        end
        else if (cmd.load_status)
        begin
            status_reg <= cmd.status;
            index_reg  <= '0;
            value_reg  <= '0;
            lost_reg   <= 1'b0;
            fs_reg     <= 1'b0;
            last_reg   <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign frame_drop    = lost_reg;
    assign failsafe      = fs_reg;
    assign last          = last_reg;

endmodule

@@ rtl/sbus_frame_receiver_core.sv @@
// Top level of the SBUS frame receiver: controller and datapath joined by commands and status.
`timescale 1ns / 1ps

// The input channel (in_valid, in_stall, kind, rx_byte) carries one word per received
// UART byte, UART error event or time tick. A word is taken on a rising edge with
// in_valid high and in_stall low. Bytes, errors and ticks are taken at one per cycle while
// no channel burst runs and the result register is free or being emptied in the same cycle.
// The output channel (out_valid, out_stall and the result fields) presents each result
// from a register, so a status result (bad header, UART error, timeout) appears in the
// cycle after the word that caused it. The footer byte starts a burst of 18 channel
// words, the first registered after the controller has entered its emit state and then
// one per cycle while out_stall is low; the input is stalled for the burst. The
// burst runs one channel a cycle because the datapath shifts the collected frame right
// by eleven bits per channel.
// When the receiver holds out_stall the result stays put and no further input word is
// taken until the result register can be refilled.
// The configuration channel (cfg_valid, cfg_ready, timeout_ticks) is always ready and
// should only be written while the block is idle.
// Reset returns the block to header search with the counters cleared and the timeout
// set to ten ticks; no result is pending after reset.

module sbus_frame_receiver_core
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [CHAN_IDX_W-1:0] channel_index,
    output logic [CHAN_W-1:0]     channel_value,
    output logic                  frame_drop,
    output logic                  failsafe,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TIMEOUT_W-1:0]  timeout_ticks
);

    cmd_t  cmd;
    stat_t stat;

    // The timeout register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .timeout_ticks (timeout_ticks),
        .rx_byte       (rx_byte),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .frame_drop    (frame_drop),
        .failsafe      (failsafe),
        .last          (last)
    );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the SBUS frame receiver core, with its own frame decoder model.
`timescale 1ns / 1ps

// The bench feeds the receiver a stream of words: received bytes, UART error events, time
// ticks and the spare kind that the block must ignore. A queue of pending words is filled
// by the stimulus process. A driver takes words from it and changes the inputs on the
// falling clock edge. A monitor samples the outputs on the rising edge. Each accepted
// input word is run through a decoder model here, and the words it should produce are
// queued. Every output word is checked against the oldest queued expectation. Both sides
// pause at random, apart from one long phase in which neither does. The timeout register
// is only rewritten once the receiver has gone quiet.
module testbench;
    import sfr_pkg::*;

    // The fourth kind code has no meaning and must leave the receiver untouched.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [1:0] code;
        logic [7:0] data;
    } line_word_t;

    typedef struct packed {
        status_t               status;
        logic [CHAN_IDX_W-1:0] index;
        logic [CHAN_W-1:0]     value;
        logic                  lost;
        logic                  fs;
        logic                  last;
    } chan_word_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind          = KIND_BYTE;
    logic [7:0]            rx_byte       = 8'h00;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [1:0]            status;
    logic [CHAN_IDX_W-1:0] channel_index;
    logic [CHAN_W-1:0]     channel_value;
    logic                  frame_drop;
    logic                  failsafe;
    logic                  last;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [TIMEOUT_W-1:0]  timeout_ticks = '0;

    // State of the decoder model, kept at the widths of the block.
    state_t                rx_phase    = ST_HEAD;
    logic [BYTE_CNT_W-1:0] rx_count    = '0;
    logic [FRAME_W-1:0]    rx_frame    = '0;
    logic [TICK_W-1:0]     rx_ticks    = '0;
    logic [TIMEOUT_W-1:0]  limit_ticks = TIMEOUT_W'(TIMEOUT_RESET);

    line_word_t word_q[$];
    chan_word_t decoded_q[$];
    bit         word_live    = 1'b0;
    bit         steady       = 1'b0;
    int         faults       = 0;
    int         queued_items = 0;
    int         cycles       = 0;

    always #1 clk = ~clk;

    sbus_frame_receiver_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .frame_drop    (frame_drop),
        .failsafe      (failsafe),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .timeout_ticks (timeout_ticks)
    );

    // A side pauses with a chance of roughly eight percent, except while the steady flag is set.
    function automatic bit lull();
        return !steady && ($urandom_range(0, 99) < 8);
    endfunction

    // Only the first few faults are printed; all of them are counted.
    function automatic void report_fault(string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic string show(chan_word_t w);
        return $sformatf("status %0d channel %0d value %0d lost %b failsafe %b last %b",
                         w.status, w.index, w.value, w.lost, w.fs, w.last);
    endfunction

    // An aborted frame yields a single status word and sends the decoder back to header search.
    function automatic void drop_frame(status_t st);
        rx_phase  = ST_HEAD;
        rx_count  = '0;
        rx_ticks  = '0;
        decoded_q.push_back('{st, '0, '0, 1'b0, 1'b0, 1'b1});
    endfunction

    // Decoder model: works out the output words that one accepted input word should cause.
    function automatic void decode_word(logic [1:0] code, logic [7:0] data);
        logic [7:0] flags;
        logic       lost_f;
        logic       fs_f;
        case (code)
            KIND_UART_ERR: drop_frame(STS_UART_ERR);
            KIND_TICK:
            begin
                // The tick counter saturates; any phase may time out, idle header search too.
                if (rx_ticks != '1)
                    rx_ticks++;
                if (CMP_W'(rx_ticks) >= CMP_W'(limit_ticks))
                    drop_frame(STS_TIMEOUT);
            end
            KIND_BYTE:
            begin
                case (rx_phase)
                    ST_DATA:
                    begin
                        rx_frame[rx_count * 8 +: 8] = data;
                        rx_count++;
                        if (rx_count >= DATA_BYTES)
                        begin
                            rx_phase = ST_FOOT;
                            rx_ticks = '0;
                        end
                    end
                    ST_FOOT:
                    begin
                        // The footer is taken unchecked and releases the channel burst.
                        rx_phase = ST_HEAD;
                        rx_count = '0;
                        rx_ticks = '0;
                        flags    = rx_frame[FRAME_W-8 +: 8];
                        lost_f   = flags[2];
                        fs_f     = flags[3];
                        for (int ch = 0; ch < NUM_PROP; ch++)
                            decoded_q.push_back('{STS_DATA, CHAN_IDX_W'(ch),
                                                  rx_frame[ch * CHAN_W +: CHAN_W],
                                                  lost_f, fs_f, 1'b0});
                        decoded_q.push_back('{STS_DATA, CH_DIG0, CHAN_W'(flags[0]),
                                              lost_f, fs_f, 1'b0});
                        decoded_q.push_back('{STS_DATA, CH_DIG1, CHAN_W'(flags[1]),
                                              lost_f, fs_f, 1'b1});
                    end
                    default:
                    begin
                        // Header search: a good or a bad header both end the segment.
                        rx_phase = ST_HEAD;
                        rx_count = '0;
                        rx_ticks = '0;
                        if (data == SYNC_BYTE)
                            rx_phase = ST_DATA;
                        else
                            decoded_q.push_back('{STS_BAD_HEADER, '0, '0, 1'b0, 1'b0, 1'b1});
                    end
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic void push_word(logic [1:0] code, logic [7:0] data);
        word_q.push_back('{code, data});
        if (code != KIND_SPARE)
            queued_items++;
    endfunction

    // Byte values lean towards the extremes and the sync value, so that data bytes equal
    // to the header are seen inside frames as well.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return SYNC_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    // A complete frame, with ticks scattered between its bytes at the given percentage.
    function automatic void push_frame(int tick_pct, bit ones);
        push_word(KIND_BYTE, SYNC_BYTE);
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                push_word(KIND_TICK, 8'($urandom));
            push_word(KIND_BYTE, ones ? 8'hFF : rand_byte());
        end
        if ($urandom_range(0, 99) < tick_pct)
            push_word(KIND_TICK, 8'($urandom));
        push_word(KIND_BYTE, ones ? 8'hFF : rand_byte());
    endfunction

    // Mostly whole frames with random content; the rest is truncated frames, stray bytes,
    // UART errors, tick bursts and words of the spare kind.
    function automatic void push_random(int n);
        int target;
        int pick;
        int depth;
        target = queued_items + n;
        while (queued_items < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                push_frame(($urandom_range(0, 3) == 0) ? 8 : 0, 1'b0);
            else if (pick < 65)
            begin
                push_word(KIND_BYTE, SYNC_BYTE);
                depth = $urandom_range(0, DATA_BYTES);
                repeat (depth) push_word(KIND_BYTE, rand_byte());
                case ($urandom_range(0, 2))
                    0:       push_word(KIND_UART_ERR, 8'($urandom));
                    1:       repeat ($urandom_range(1, 12)) push_word(KIND_TICK, 8'($urandom));
                    default: ;
                endcase
            end
            else if (pick < 75)
                push_word(KIND_BYTE, rand_byte());
            else if (pick < 83)
                push_word(KIND_UART_ERR, 8'($urandom));
            else if (pick < 94)
                repeat ($urandom_range(1, 12)) push_word(KIND_TICK, 8'($urandom));
            else
                push_word(KIND_SPARE, 8'($urandom));
        end
    endfunction

    // Waits for the queue to empty and every expected word to arrive, then lets the block
    // run on for a while so that a late or stray word is still caught.
    task automatic settle();
        int waited;
        waited = 0;
        while (word_q.size() != 0 || word_live)
            @(posedge clk);
        while (decoded_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (decoded_q.size() != 0)
        begin
            report_fault($sformatf("%0d expected words never arrived, oldest %s",
                                   decoded_q.size(), show(decoded_q[0])));
            decoded_q.delete();
        end
    endtask

    // Writes the timeout register; the model takes the value at the same edge as the block.
    task automatic write_limit(logic [TIMEOUT_W-1:0] value);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        timeout_ticks <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_ticks = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Driver: presents the next word on the falling edge and holds it until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && !word_live)
        begin
            if (word_q.size() != 0 && !lull())
            begin
                in_valid  <= 1'b1;
                kind      <= word_q[0].code;
                rx_byte   <= word_q[0].data;
                word_live  = 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
                kind     <= 2'($urandom);
                rx_byte  <= 8'($urandom);
            end
        end
    end

    // Intake: a word taken by the block is decoded by the model at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            decode_word(kind, rx_byte);
            void'(word_q.pop_front());
            word_live = 1'b0;
        end
    end

    // The receiving side stalls at random as well.
    always @(negedge clk)
    begin
        out_stall <= rst_n ? lull() : 1'b0;
    end

    // Monitor: every word handed over is compared with the oldest expectation.
    always @(posedge clk)
    begin : watch
        chan_word_t seen;
        chan_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{status_t'(status), channel_index, channel_value, frame_drop, failsafe,
                     last};
            if (decoded_q.size() == 0)
                report_fault($sformatf("unexpected word: %s", show(seen)));
            else
            begin
                want = decoded_q.pop_front();
                if (seen.status !== want.status || seen.index !== want.index ||
                    seen.value !== want.value || seen.lost !== want.lost ||
                    seen.fs !== want.fs || seen.last !== want.last)
                    report_fault($sformatf("mismatch: expected %s, got %s",
                                           show(want), show(seen)));
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset timeout of ten ticks: bad headers at both byte
        // extremes, the spare kind, a UART error in header search, a frame of all ones,
        // a UART error in the data segment and a run of ticks that times out.
        push_word(KIND_BYTE, 8'h00);
        push_word(KIND_BYTE, 8'hFF);
        push_word(KIND_SPARE, 8'hA5);
        push_word(KIND_UART_ERR, 8'h5A);
        push_frame(0, 1'b1);
        push_word(KIND_BYTE, SYNC_BYTE);
        push_word(KIND_BYTE, 8'h00);
        push_word(KIND_UART_ERR, 8'hFF);
        repeat (TIMEOUT_RESET) push_word(KIND_TICK, 8'h00);
        settle();

        // A zero timeout turns every tick into a timeout; a frame without ticks still passes.
        write_limit('0);
        push_word(KIND_TICK, 8'hFF);
        push_word(KIND_TICK, 8'h00);
        push_frame(0, 1'b0);
        push_word(KIND_BYTE, SYNC_BYTE);
        push_word(KIND_TICK, 8'h3C);
        settle();

        write_limit(TIMEOUT_W'(1));
        push_random(60);
        settle();

        // Largest timeout, with neither side pausing.
        steady = 1'b1;
        write_limit('1);
        push_random(80);
        settle();
        steady = 1'b0;

        write_limit(TIMEOUT_W'($urandom_range(2, 40)));
        push_random(100);
        settle();

        write_limit(TIMEOUT_W'(TIMEOUT_RESET));
        push_random(80);
        settle();

        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
